@@ rtl/can_afb_pkg.sv @@
`default_nettype none

package can_afb_pkg;

   // Bank dimensions
   localparam int FILTER_COUNT_DEF = 32;
   localparam int IDENT_BITS_DEF   = 29;

   // Fixed field widths
   localparam int FIELD_W     = 29;
   localparam int SLOT_W      = 5;
   localparam int ROUTE_W     = 2;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAILBOX_ENABLES = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_GENERAL_ENABLE  = CSR_INDEX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_CLASSIFY = 2'd0,
      OP_SET_AT   = 2'd1,
      OP_SET_FREE = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [ROUTE_W-1:0] {
      ROUTE_MAILBOX = 2'd0,
      ROUTE_GENERAL = 2'd1,
      ROUTE_QUEUE   = 2'd2
   } route_type;

   // Update request towards the filter bank
   typedef struct packed {
      logic              clear;
      logic              set_at;
      logic              set_free;
      logic [SLOT_W-1:0] slot_sel;
   } bank_cmd_type;

   // Lookup outcome from the filter bank
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] hit_slot;
      logic              free_found;
      logic [SLOT_W-1:0] free_slot;
   } bank_status_type;

endpackage

`default_nettype wire

@@ rtl/can_afb_bank.sv @@
`default_nettype none

module can_afb_bank
   import can_afb_pkg::*;
#(
   parameter int FILTER_COUNT = FILTER_COUNT_DEF,
   parameter int IDENT_BITS   = IDENT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bank_cmd_type           bank_cmd,
   input  logic [FIELD_W-1:0]     frame_ident,
   input  logic                   frame_is_extended,
   input  logic [FIELD_W-1:0]     new_ident,
   input  logic [FIELD_W-1:0]     new_mask,
   input  logic                   new_extended,
   output bank_status_type        bank_status
);

   logic [IDENT_BITS-1:0]   ident_ff [FILTER_COUNT];
   logic [IDENT_BITS-1:0]   mask_ff  [FILTER_COUNT];
   logic [FILTER_COUNT-1:0] ext_ff;
   logic [FILTER_COUNT-1:0] used_ff;
   logic [FILTER_COUNT-1:0] used_in;

   logic [IDENT_BITS-1:0]   ident_in;
   logic [IDENT_BITS-1:0]   mask_in;
   logic [IDENT_BITS-1:0]   frame_cut;

   logic [FILTER_COUNT-1:0] match;
   logic [FILTER_COUNT-1:0] match_first;
   logic [FILTER_COUNT-1:0] free;
   logic [FILTER_COUNT-1:0] free_first;
   logic [FILTER_COUNT-1:0] at_dec;
   logic [FILTER_COUNT-1:0] wr_onehot;
   logic [SLOT_W-1:0]       hit_slot;
   logic [SLOT_W-1:0]       free_slot;

   assign frame_cut = frame_ident[IDENT_BITS-1:0];
   assign mask_in   = new_mask[IDENT_BITS-1:0];
   assign ident_in  = new_ident[IDENT_BITS-1:0] & mask_in;

   // Compare every slot in parallel; decode the slot select
   always_comb begin
      for (int s = 0; s < FILTER_COUNT; s++) begin
         match[s]  = used_ff[s] && ((frame_cut & mask_ff[s]) == ident_ff[s]) &&
                     (ext_ff[s] == frame_is_extended);
         at_dec[s] = (bank_cmd.slot_sel == SLOT_W'(s));
      end
   end

   // Isolate the lowest set bit
   assign free        = ~used_ff;
   assign match_first = match & (~match + FILTER_COUNT'(1));
   assign free_first  = free & (~free + FILTER_COUNT'(1));

   always_comb begin
      hit_slot  = '0;
      free_slot = '0;
      for (int s = 0; s < FILTER_COUNT; s++) begin
         if (match_first[s]) begin
            hit_slot = hit_slot | SLOT_W'(s);
         end
         if (free_first[s]) begin
            free_slot = free_slot | SLOT_W'(s);
         end
      end
   end

   assign bank_status.hit        = |match;
   assign bank_status.hit_slot   = hit_slot;
   assign bank_status.free_found = |free;
   assign bank_status.free_slot  = free_slot;

   always_comb begin
      if (bank_cmd.set_at) begin
         wr_onehot = at_dec;
      end else if (bank_cmd.set_free) begin
         wr_onehot = free_first;
      end else begin
         wr_onehot = '0;
      end
   end

   assign used_in = bank_cmd.clear ? '0 : (used_ff | wr_onehot);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Filter contents only matter while the slot is in use
   always_ff @(posedge clock) begin
      for (int s = 0; s < FILTER_COUNT; s++) begin
         if (wr_onehot[s]) begin
            ident_ff[s] <= ident_in;
            mask_ff[s]  <= mask_in;
            ext_ff[s]   <= new_extended;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/can_acceptance_filter_bank.sv @@
// CAN acceptance filter bank.
// Request channel (req_*): one operation per transfer - classify a received
// frame, store a filter at a chosen slot, store a filter in the lowest free
// slot, or clear every filter. Response channel (rsp_*): exactly one result
// per request, in order: success, slot index and route of the frame.
// Configuration (csr_*): a write lands on the edge where csr_write_enable is
// high; index 0 holds the per-slot mailbox callback enables, index 1 the
// general callback enable, other indexes are dropped. Write only when idle.
// Flow: a request taken into the input register is classified against all
// slots at once and moves into the result register, which drives rsp_valid,
// once that register is free or being drained by rsp_ready.
// Throughput: one request per cycle while rsp_ready is high, set by the single
// parallel compare and lowest-slot search over the whole bank between registers.
// A stalled receiver holds the result register; the input register still
// takes one more request, then req_ready drops until the response drains.
// Reset: all filters become free, both callback enables clear, both
// registers empty. No clearing pass is needed.

`default_nettype none

module can_acceptance_filter_bank
   import can_afb_pkg::*;
#(
   parameter int FILTER_COUNT = FILTER_COUNT_DEF,
   parameter int IDENT_BITS   = IDENT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [FIELD_W-1:0]     req_frame_ident,
   input  logic                   req_frame_is_extended,
   input  logic [SLOT_W-1:0]      req_slot_select,
   input  logic [FIELD_W-1:0]     req_new_ident,
   input  logic [FIELD_W-1:0]     req_new_mask,
   input  logic                   req_new_extended,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_success,
   output logic [SLOT_W-1:0]      rsp_slot_index,
   output logic [ROUTE_W-1:0]     rsp_route,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration registers
   logic [CSR_DATA_W-1:0] mailbox_en_ff;
   logic                  general_en_ff;

   // Input register
   logic                  in_valid_ff;
   logic                  in_valid_in;
   op_type                op_ff;
   logic [FIELD_W-1:0]    frame_ident_ff;
   logic                  frame_ext_ff;
   logic [SLOT_W-1:0]     slot_sel_ff;
   logic [FIELD_W-1:0]    new_ident_ff;
   logic [FIELD_W-1:0]    new_mask_ff;
   logic                  new_ext_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  success_ff;
   logic                  success_in;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     slot_in;
   route_type             route_ff;
   route_type             route_in;

   logic                  req_xfer;
   logic                  advance;
   logic                  slot_in_range;
   bank_cmd_type          bank_cmd;
   bank_status_type       bank_status;

   localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(FILTER_COUNT);

   // Advance the input register whenever the result register is free or
   // being drained this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mailbox_en_ff <= '0;
         general_en_ff <= 1'b0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MAILBOX_ENABLES) begin
            mailbox_en_ff <= csr_write_data;
         end
         if (csr_index == CSR_GENERAL_ENABLE) begin
            general_en_ff <= csr_write_data[0];
         end
      end
   end

   // Handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request payload on a transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff          <= op_type'(req_operation);
         frame_ident_ff <= req_frame_ident;
         frame_ext_ff   <= req_frame_is_extended;
         slot_sel_ff    <= req_slot_select;
         new_ident_ff   <= req_new_ident;
         new_mask_ff    <= req_new_mask;
         new_ext_ff     <= req_new_extended;
      end
   end

   // Bank updates only fire when the item moves into the result register
   assign bank_cmd.clear    = advance && (op_ff == OP_CLEAR);
   assign bank_cmd.set_at   = advance && (op_ff == OP_SET_AT);
   assign bank_cmd.set_free = advance && (op_ff == OP_SET_FREE);
   assign bank_cmd.slot_sel = slot_sel_ff;

   can_afb_bank #(
      .FILTER_COUNT (FILTER_COUNT),
      .IDENT_BITS   (IDENT_BITS)
   ) u_bank (
      .clock             (clock),
      .reset             (reset),
      .bank_cmd          (bank_cmd),
      .frame_ident       (frame_ident_ff),
      .frame_is_extended (frame_ext_ff),
      .new_ident         (new_ident_ff),
      .new_mask          (new_mask_ff),
      .new_extended      (new_ext_ff),
      .bank_status       (bank_status)
   );

   assign slot_in_range = {1'b0, slot_sel_ff} < SLOT_LIMIT;

   // Build the result from the bank state seen before this item's update
   always_comb begin
      success_in = 1'b0;
      slot_in    = '0;
      route_in   = ROUTE_MAILBOX;
      case (op_ff)
         OP_CLASSIFY: begin
            if (bank_status.hit) begin
               success_in = 1'b1;
               slot_in    = bank_status.hit_slot;
               if (mailbox_en_ff[bank_status.hit_slot]) begin
                  route_in = ROUTE_MAILBOX;
               end else if (general_en_ff) begin
                  route_in = ROUTE_GENERAL;
               end else begin
                  route_in = ROUTE_QUEUE;
               end
            end
         end
         OP_SET_AT: begin
            if (slot_in_range) begin
               success_in = 1'b1;
               slot_in    = slot_sel_ff;
            end
         end
         OP_SET_FREE: begin
            if (bank_status.free_found) begin
               success_in = 1'b1;
               slot_in    = bank_status.free_slot;
            end
         end
         OP_CLEAR: begin
            success_in = 1'b1;
         end
         default: begin
            success_in = 1'b0;
         end
      endcase
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         success_ff <= success_in;
         slot_ff    <= slot_in;
         route_ff   <= route_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = success_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_route      = route_ff;

endmodule

`default_nettype wire

@@ rtl/can_afb_checker.sv @@
`default_nettype none

module can_afb_checker
   import can_afb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic                   rsp_success,
   input  wire logic [SLOT_W-1:0]      rsp_slot_index,
   input  wire logic [ROUTE_W-1:0]     rsp_route
);

   // No response is shown in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_success) && $stable(rsp_slot_index) && $stable(rsp_route))
      else $error("response payload changed while stalled");

   // A failed operation reports slot and route as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |->
         rsp_slot_index == '0 && rsp_route == ROUTE_MAILBOX)
      else $error("failed operation carries slot or route");

   // Route code is always a known destination
   a_route_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_route == ROUTE_MAILBOX || rsp_route == ROUTE_GENERAL ||
         rsp_route == ROUTE_QUEUE)
      else $error("unknown route code");

endmodule

bind can_acceptance_filter_bank can_afb_checker u_can_afb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_success    (rsp_success),
   .rsp_slot_index (rsp_slot_index),
   .rsp_route      (rsp_route)
);

`default_nettype wire
